FILE: rtl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared types and constants for the FIFO queue with search.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    // Value reported by a dequeue on an empty queue
    localparam logic [VALUE_W-1:0] DATA_EMPTY = {VALUE_W{1'b1}};

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

FILE: rtl/fqs_ram.sv
// ----------------------------------------------------------------------------
// fqs_ram
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fqs_ram
    import fqs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [VALUE_W-1:0]       i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [VALUE_W-1:0]       o_rd_data
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search
// Enqueue, clear, rejected ops, empty search, last dequeue: registered at transfer.
// Dequeue leaving entries: one RAM read fetches the new front, S_DEQ registers it.
// Search: one RAM read per held entry, each compared in S_SRCH before the result.
// One item in flight; the next transfer is taken as the result goes out.
// Reset (synchronous, active low) clears pointers and count, not the store.
// ----------------------------------------------------------------------------
module fifo_queue_with_search
    import fqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [1:0]                i_op,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [1:0]                o_status,
    output logic signed [VALUE_W-1:0] o_data_out,
    output logic                      o_found,
    output logic [OCC_W-1:0]          o_occupancy,
    output logic                      o_is_empty,
    output logic signed [VALUE_W-1:0] o_front_value,
    output logic signed [VALUE_W-1:0] o_back_value
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEQ,
        S_SRCH
    } t_state;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [OCC_W-1:0] f_occ(input logic [CW-1:0] c);
        logic [CW+OCC_W-1:0] ext;
        ext = {{OCC_W{1'b0}}, c};
        return ext[OCC_W-1:0];
    endfunction

    t_state             r_state;
    logic [AW-1:0]      r_head;
    logic [AW-1:0]      r_tail;
    logic [CW-1:0]      r_count;
    logic [VALUE_W-1:0] r_front;
    logic [VALUE_W-1:0] r_back;
    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_left;
    logic [VALUE_W-1:0] r_key;
    logic               r_found;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [VALUE_W-1:0] r_out_data;
    logic               r_out_found;
    logic [OCC_W-1:0]   r_out_occ;
    logic               r_out_empty;
    logic [VALUE_W-1:0] r_out_front;
    logic [VALUE_W-1:0] r_out_back;

    logic               w_out_free;
    logic               w_accept;
    t_op                w_op;
    logic               w_wr_en;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [VALUE_W-1:0] w_rd_data;
    logic               w_hit;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign w_op       = t_op'(i_op);
    assign w_wr_en    = w_accept && (w_op == OP_ENQ) && (r_count != FULL_CNT);
    assign w_hit      = (w_rd_data == r_key);

    // Pick the RAM read: next front on a dequeue, one entry per cycle on a search
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_head;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_op == OP_DEQ)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = f_next(r_head);
                end else if (w_accept && (w_op == OP_SEARCH)) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_head;
                end
            end
            S_SRCH: begin
                if (r_left != '0) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_ptr;
                end
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    fqs_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (i_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_op)
                            OP_ENQ: begin
                                r_out_valid <= 1'b1;
                                r_out_data  <= '0;
                                r_out_found <= 1'b0;
                                if (r_count == FULL_CNT) begin
                                    r_out_status <= ST_FULL;
                                    r_out_occ    <= f_occ(r_count);
                                    r_out_empty  <= 1'b0;
                                    r_out_front  <= r_front;
                                    r_out_back   <= r_back;
                                end else begin
                                    r_out_status <= ST_OK;
                                    r_tail       <= f_next(r_tail);
                                    r_count      <= r_count + CW'(1);
                                    r_back       <= i_value;
                                    r_out_occ    <= f_occ(r_count + CW'(1));
                                    r_out_empty  <= 1'b0;
                                    r_out_back   <= i_value;
                                    if (r_count == '0) begin
                                        r_front     <= i_value;
                                        r_out_front <= i_value;
                                    end else begin
                                        r_out_front <= r_front;
                                    end
                                end
                            end
                            OP_DEQ: begin
                                r_out_found <= 1'b0;
                                if (r_count == '0) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_EMPTY;
                                    r_out_data   <= DATA_EMPTY;
                                    r_out_occ    <= '0;
                                    r_out_empty  <= 1'b1;
                                    r_out_front  <= '0;
                                    r_out_back   <= '0;
                                end else begin
                                    r_out_status <= ST_OK;
                                    r_out_data   <= r_front;
                                    r_head       <= f_next(r_head);
                                    r_count      <= r_count - CW'(1);
                                    if (r_count == CW'(1)) begin
                                        r_out_valid <= 1'b1;
                                        r_out_occ   <= '0;
                                        r_out_empty <= 1'b1;
                                        r_out_front <= '0;
                                        r_out_back  <= '0;
                                    end else begin
                                        // wait in S_DEQ for the RAM read of the new front
                                        r_out_valid <= 1'b0;
                                        r_state     <= S_DEQ;
                                    end
                                end
                            end
                            OP_SEARCH: begin
                                r_out_status <= ST_OK;
                                r_out_data   <= '0;
                                if (r_count == '0) begin
                                    r_out_valid <= 1'b1;
                                    r_out_found <= 1'b0;
                                    r_out_occ   <= '0;
                                    r_out_empty <= 1'b1;
                                    r_out_front <= '0;
                                    r_out_back  <= '0;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_key       <= i_value;
                                    r_found     <= 1'b0;
                                    r_ptr       <= f_next(r_head);
                                    r_left      <= r_count - CW'(1);
                                    r_state     <= S_SRCH;
                                end
                            end
                            default: begin
                                r_head       <= '0;
                                r_tail       <= '0;
                                r_count      <= '0;
                                r_out_valid  <= 1'b1;
                                r_out_status <= ST_OK;
                                r_out_data   <= '0;
                                r_out_found  <= 1'b0;
                                r_out_occ    <= '0;
                                r_out_empty  <= 1'b1;
                                r_out_front  <= '0;
                                r_out_back   <= '0;
                            end
                        endcase
                    end else if (!i_stall) begin
                        // Drop the result once it is transferred
                        r_out_valid <= 1'b0;
                    end
                end
                S_DEQ: begin
                    r_front     <= w_rd_data;
                    r_out_valid <= 1'b1;
                    r_out_occ   <= f_occ(r_count);
                    r_out_empty <= 1'b0;
                    r_out_front <= w_rd_data;
                    r_out_back  <= r_back;
                    r_state     <= S_IDLE;
                end
                S_SRCH: begin
                    // compare the entry read last cycle, advance while entries remain
                    if (r_left != '0) begin
                        r_ptr   <= f_next(r_ptr);
                        r_left  <= r_left - CW'(1);
                        r_found <= r_found | w_hit;
                    end else begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_found | w_hit;
                        r_out_occ   <= f_occ(r_count);
                        r_out_empty <= 1'b0;
                        r_out_front <= r_front;
                        r_out_back  <= r_back;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_data_out    = r_out_data;
    assign o_found       = r_out_found;
    assign o_occupancy   = r_out_occ;
    assign o_is_empty    = r_out_empty;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds queue depth");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while an item is still in work");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_count == $past(r_count) + CW'(1)))
        else $error("enqueue did not advance the count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |->
            (o_front_value == '0 && o_back_value == '0 && o_occupancy == '0))
        else $error("empty result carries nonzero front, back or occupancy");
`endif

endmodule
